>>> rtl/mluq_pkg.sv
// Shared constants, types and table builders for the mu-law / uniform quantizer.
// The threshold and reconstruction tables are computed here at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package mluq_pkg;

   // Quantizer parameters
   localparam int UNIFORM_STEP  = 128;
   localparam int MU_FULL_SCALE = 8192;
   localparam int MU_VALUE      = 255;
   localparam int FRAC_BITS     = 30;
   localparam int EXP_LIMIT     = 17;
   localparam int LEVEL_CAP     = 65535;
   localparam int ROM_SIZE      = 2 * MU_FULL_SCALE / UNIFORM_STEP + 2;
   localparam int NUM_THR       = ROM_SIZE - 1;

   // Field and datapath widths
   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 17;
   localparam int SGN_W     = MAG_W + 1;
   localparam int UNI_ERR_W = 8;
   localparam int CMP_ERR_W = 13;
   localparam int Q_W       = $clog2(ROM_SIZE);
   localparam int TAB_SIZE  = 1 << Q_W;
   localparam int HALF_STEP = UNIFORM_STEP / 2;

   // Fixed-point constants for the table builder
   localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
   localparam logic [63:0] HALF_Q   = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] ROOT_TOP = 64'd1 << (2 * FRAC_BITS + 1);
   localparam logic [63:0] FS_Q     = 64'(MU_FULL_SCALE);
   localparam logic [63:0] DEN_Q    = 64'(MU_VALUE) << FRAC_BITS;
   localparam logic [63:0] DEN_HALF = DEN_Q >> 1;
   localparam logic [63:0] CAP_Q    = 64'(LEVEL_CAP);

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [Q_W-1:0]   idx_type;
   typedef logic [SGN_W-1:0] sgn_type;

   // Threshold that no magnitude reaches
   localparam mag_type THR_NONE = '1;

   // Floored integer square root
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_w;
      rem   = v;
      res   = '0;
      bit_w = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Expansion (2^x - 1) * FS / 255 at x = num / FS, ceiling or round half up
   function automatic logic [63:0] expand_val(input logic [63:0] num, input logic round_up);
      logic [63:0] ip;
      logic [63:0] fr;
      logic [63:0] frac;
      logic [63:0] m;
      logic [63:0] root;
      logic [63:0] v;
      logic [63:0] prod;
      logic [63:0] r;
      ip   = num / FS_Q;
      fr   = num % FS_Q;
      frac = (fr << FRAC_BITS) / FS_Q;
      m    = ONE_Q;
      root = ROOT_TOP;
      for (int i = 1; i <= FRAC_BITS; i++) begin
         if (i == 1) begin
            root = isqrt64(ROOT_TOP);
         end else begin
            root = isqrt64(root << FRAC_BITS);
         end
         if (frac[FRAC_BITS - i]) begin
            m = (m * root + HALF_Q) >> FRAC_BITS;
         end
      end
      v    = m << ip;
      prod = (v - ONE_Q) * FS_Q;
      if (round_up) begin
         r = (prod + DEN_Q - 64'd1) / DEN_Q;
      end else begin
         r = (prod + DEN_HALF) / DEN_Q;
      end
      if (ip >= 64'(EXP_LIMIT) || r > CAP_Q) begin
         r = CAP_Q;
      end
      return r;
   endfunction

   // Decision threshold k of the compressed domain
   function automatic mag_type thr_at(input int k);
      logic [63:0] t;
      t = '0;
      if (k < 1 || k > NUM_THR) begin
         return THR_NONE;
      end
      t = expand_val(64'((2 * k - 1) * 4 * UNIFORM_STEP), 1'b1);
      return mag_type'(t);
   endfunction

   // Reconstruction level k of the compressed domain
   function automatic mag_type lvl_at(input int k);
      logic [63:0] t;
      t = '0;
      if (k < 1 || k > NUM_THR) begin
         return '0;
      end
      t = expand_val(64'(k * 8 * UNIFORM_STEP), 1'b0);
      return mag_type'(t);
   endfunction

endpackage

>>> rtl/mu_law_and_uniform_quantizer_core.sv
// Top level of the mu-law (mu = 255) companding quantizer and uniform quantizer.
// Depends on mluq_pkg for widths, constants and table contents.
`timescale 1ns / 1ps

// Takes one signed 16-bit sample per cycle while not stalled and returns, for
// each sample, the magnitude rounded half up to a multiple of 128 and the
// mu-law companded (compress, quantize to 128-wide steps, expand) value, both
// with the sample's sign, plus the two quantization errors. Throughput is one
// sample per clock while rsp_stall is low. Stages: one input register, an
// 8-stage binary search of the compressed-domain threshold table (one index
// bit per stage), a level lookup register and the output register. Each
// stage holds its item only while the next stage is full and stalled, so
// empty slots are squeezed out and req_stall rises only when the pipe is full.
module mu_law_and_uniform_quantizer_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [mluq_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [mluq_pkg::MAG_W-1:0]        rsp_uniform_value,
   output logic signed [mluq_pkg::MAG_W-1:0]        rsp_companded_value,
   output logic signed [mluq_pkg::UNI_ERR_W-1:0]    rsp_uniform_error,
   output logic signed [mluq_pkg::CMP_ERR_W-1:0]    rsp_companded_error
);

   localparam int NUM_ST = mluq_pkg::Q_W + 3;
   localparam int LVL_ST = mluq_pkg::Q_W + 1;
   localparam int OUT_ST = mluq_pkg::Q_W + 2;

   // Constant tables
   mluq_pkg::mag_type thr_tab [mluq_pkg::TAB_SIZE];
   mluq_pkg::mag_type lvl_tab [mluq_pkg::TAB_SIZE];

   for (genvar k = 0; k < mluq_pkg::TAB_SIZE; k++) begin : g_tab
      localparam mluq_pkg::mag_type ThrVal = mluq_pkg::thr_at(k);
      localparam mluq_pkg::mag_type LvlVal = mluq_pkg::lvl_at(k);
      assign thr_tab[k] = ThrVal;
      assign lvl_tab[k] = LvlVal;
   end

   // Pipeline control
   logic [NUM_ST-1:0] valid_ff;
   logic [NUM_ST-1:0] adv;

   // Search pipeline payload (index 0 is the input register)
   mluq_pkg::mag_type                 mag_ff    [mluq_pkg::Q_W+1];
   mluq_pkg::mag_type                 uni_ff    [mluq_pkg::Q_W+1];
   logic                              neg_ff    [mluq_pkg::Q_W+1];
   logic [mluq_pkg::SAMPLE_W-1:0]     sample_ff [mluq_pkg::Q_W+1];
   mluq_pkg::idx_type                 q_ff      [mluq_pkg::Q_W+1];

   // Level stage payload
   mluq_pkg::sgn_type                 lvl_uni_ff;
   mluq_pkg::sgn_type                 lvl_comp_ff;
   logic [mluq_pkg::SAMPLE_W-1:0]     lvl_sample_ff;

   // Output registers
   logic [mluq_pkg::MAG_W-1:0]        out_uni_ff;
   logic [mluq_pkg::MAG_W-1:0]        out_comp_ff;
   logic [mluq_pkg::UNI_ERR_W-1:0]    out_uni_err_ff;
   logic [mluq_pkg::CMP_ERR_W-1:0]    out_comp_err_ff;

   // Input stage logic
   logic                              neg_in;
   mluq_pkg::mag_type                 samp_ext;
   mluq_pkg::mag_type                 mag_in;
   mluq_pkg::mag_type                 uni_sum;
   mluq_pkg::mag_type                 uni_in;

   // Level and output stage logic
   mluq_pkg::mag_type                 lvl_mag;
   mluq_pkg::sgn_type                 uni_sgn_in;
   mluq_pkg::sgn_type                 comp_sgn_in;
   mluq_pkg::sgn_type                 samp_sgn;
   mluq_pkg::sgn_type                 uni_err_in;
   mluq_pkg::sgn_type                 comp_err_in;

   // Advance a stage when it is empty or the stage after it advances
   always_comb begin
      logic open_path;
      open_path = !rsp_stall;
      for (int i = NUM_ST - 1; i >= 0; i--) begin
         open_path = open_path || !valid_ff[i];
         adv[i]    = open_path;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NUM_ST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_ST; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Take magnitude and round it to the uniform step
   assign neg_in   = req_sample[mluq_pkg::SAMPLE_W-1];
   assign samp_ext = mluq_pkg::MAG_W'(req_sample);
   assign mag_in   = neg_in ? (mluq_pkg::mag_type'(0) - samp_ext) : samp_ext;
   assign uni_sum  = mag_in + mluq_pkg::MAG_W'(mluq_pkg::HALF_STEP);
   assign uni_in   = mluq_pkg::MAG_W'((uni_sum / mluq_pkg::UNIFORM_STEP)
                                      * mluq_pkg::UNIFORM_STEP);

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mag_ff[0]    <= mag_in;
         uni_ff[0]    <= uni_in;
         neg_ff[0]    <= neg_in;
         sample_ff[0] <= req_sample;
         q_ff[0]      <= '0;
      end
   end

   // Binary search for the largest threshold index at or below the magnitude
   for (genvar s = 1; s <= mluq_pkg::Q_W; s++) begin : g_srch
      localparam int BitPos = mluq_pkg::Q_W - s;
      mluq_pkg::idx_type cand;
      logic              hit;

      assign cand = q_ff[s-1] | (mluq_pkg::idx_type'(1) << BitPos);
      assign hit  = mag_ff[s-1] >= thr_tab[cand];

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            mag_ff[s]    <= mag_ff[s-1];
            uni_ff[s]    <= uni_ff[s-1];
            neg_ff[s]    <= neg_ff[s-1];
            sample_ff[s] <= sample_ff[s-1];
            q_ff[s]      <= hit ? cand : q_ff[s-1];
         end
      end
   end

   // Look up the level and restore the sign on both values
   assign lvl_mag     = lvl_tab[q_ff[mluq_pkg::Q_W]];
   assign uni_sgn_in  = neg_ff[mluq_pkg::Q_W]
                        ? (mluq_pkg::sgn_type'(0) - mluq_pkg::SGN_W'(uni_ff[mluq_pkg::Q_W]))
                        : mluq_pkg::SGN_W'(uni_ff[mluq_pkg::Q_W]);
   assign comp_sgn_in = neg_ff[mluq_pkg::Q_W]
                        ? (mluq_pkg::sgn_type'(0) - mluq_pkg::SGN_W'(lvl_mag))
                        : mluq_pkg::SGN_W'(lvl_mag);

   always_ff @(posedge clock) begin
      if (adv[LVL_ST]) begin
         lvl_uni_ff    <= uni_sgn_in;
         lvl_comp_ff   <= comp_sgn_in;
         lvl_sample_ff <= sample_ff[mluq_pkg::Q_W];
      end
   end

   // Form the errors and hold the result for the output transfer
   assign samp_sgn    = mluq_pkg::SGN_W'($signed(lvl_sample_ff));
   assign uni_err_in  = samp_sgn - lvl_uni_ff;
   assign comp_err_in = samp_sgn - lvl_comp_ff;

   always_ff @(posedge clock) begin
      if (adv[OUT_ST]) begin
         out_uni_ff      <= lvl_uni_ff[mluq_pkg::MAG_W-1:0];
         out_comp_ff     <= lvl_comp_ff[mluq_pkg::MAG_W-1:0];
         out_uni_err_ff  <= uni_err_in[mluq_pkg::UNI_ERR_W-1:0];
         out_comp_err_ff <= comp_err_in[mluq_pkg::CMP_ERR_W-1:0];
      end
   end

   assign rsp_uniform_value   = $signed(out_uni_ff);
   assign rsp_companded_value = $signed(out_comp_ff);
   assign rsp_uniform_error   = $signed(out_uni_err_ff);
   assign rsp_companded_error = $signed(out_comp_err_ff);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for mu_law_and_uniform_quantizer_core: random and directed
// samples with a built-in quantizer model and an in-order result ledger.
// Depends on mluq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
   import mluq_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int MAG_CEILING   = 1 << (SAMPLE_W - 1);
   localparam int HOLD_OFF_LEN  = 400;

   // One predicted or observed transfer on the result channel
   typedef struct packed {
      logic [MAG_W-1:0]     uni_val;
      logic [MAG_W-1:0]     comp_val;
      logic [UNI_ERR_W-1:0] uni_err;
      logic [CMP_ERR_W-1:0] comp_err;
   } quant_result_type;

   // Quantizer model plus the queue of results still owed by the core
   class quantizer_ledger;
      longint unsigned  root_q30[FRAC_BITS+1];
      int               threshold_rom[ROM_SIZE];
      int               level_rom[ROM_SIZE];
      int               level_count;
      quant_result_type pending_quants[$];
      int               mismatches;

      function new();
         int              k;
         int              t;
         bit              building;
         mismatches = 0;
         // square-root chain: root_q30[i] is 2^(2^-i) in Q30 for i >= 1; root_q30[0] is 1.0
         root_q30[0] = 64'd1 << FRAC_BITS;
         root_q30[1] = floor_sqrt(64'd1 << (2 * FRAC_BITS + 1));
         for (int i = 2; i <= FRAC_BITS; i++) begin
            root_q30[i] = floor_sqrt(root_q30[i-1] << FRAC_BITS);
         end
         // decision thresholds and reconstruction levels of the compressed domain
         threshold_rom[0] = 0;
         level_rom[0]     = 0;
         level_count      = 0;
         k                = 1;
         building         = 1'b1;
         while (building && k < ROM_SIZE) begin
            t = mu_expand((2 * k - 1) * 4 * UNIFORM_STEP, 1'b1);
            if (t > MAG_CEILING) begin
               building = 1'b0;
            end else begin
               threshold_rom[k] = t;
               level_rom[k]     = mu_expand(k * 8 * UNIFORM_STEP, 1'b0);
               level_count      = k;
               k++;
            end
         end
      endfunction

      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // (2^(num/FS) - 1) * FS / 255, ceiling or round half up, saturating
      function int mu_expand(longint unsigned num, bit round_up);
         longint unsigned fs;
         longint unsigned ip;
         longint unsigned fr;
         longint unsigned frac;
         longint unsigned m;
         longint unsigned prod;
         longint unsigned den;
         longint unsigned r;
         fs = MU_FULL_SCALE;
         ip = num / fs;
         fr = num % fs;
         if (ip >= EXP_LIMIT) return LEVEL_CAP;
         frac = (fr << FRAC_BITS) / fs;
         m    = 64'd1 << FRAC_BITS;
         for (int i = 1; i <= FRAC_BITS; i++) begin
            if (((frac >> (FRAC_BITS - i)) & 64'd1) != 0) begin
               m = (m * root_q30[i] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            end
         end
         prod = ((m << ip) - (64'd1 << FRAC_BITS)) * fs;
         den  = MU_VALUE;
         den  = den << FRAC_BITS;
         if (round_up) begin
            r = (prod + den - 1) / den;
         end else begin
            r = (prod + (den >> 1)) / den;
         end
         if (r > LEVEL_CAP) r = LEVEL_CAP;
         return int'(r);
      endfunction

      function quant_result_type quantize_sample(logic signed [SAMPLE_W-1:0] s);
         int               sv;
         int               a;
         int               uni;
         int               su;
         int               sc;
         int               q;
         quant_result_type r;
         sv  = s;
         a   = (sv < 0) ? -sv : sv;
         uni = ((2 * a + UNIFORM_STEP) / (2 * UNIFORM_STEP)) * UNIFORM_STEP;
         q   = 0;
         while (q < level_count && a >= threshold_rom[q+1]) q++;
         su         = (sv < 0) ? -uni : uni;
         sc         = (sv < 0) ? -level_rom[q] : level_rom[q];
         r.uni_val  = MAG_W'(su);
         r.comp_val = MAG_W'(sc);
         r.uni_err  = UNI_ERR_W'(sv - su);
         r.comp_err = CMP_ERR_W'(sv - sc);
         return r;
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         pending_quants.push_back(quantize_sample(s));
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(quant_result_type got);
         quant_result_type want;
         if (pending_quants.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                     $signed(got.uni_val), $signed(got.comp_val),
                     $signed(got.uni_err), $signed(got.comp_err));
            mismatches++;
            return;
         end
         want = pending_quants.pop_front();
         compare_field("uniform_value", $signed(want.uni_val), $signed(got.uni_val));
         compare_field("companded_value", $signed(want.comp_val), $signed(got.comp_val));
         compare_field("uniform_error", $signed(want.uni_err), $signed(got.uni_err));
         compare_field("companded_error", $signed(want.comp_err), $signed(got.comp_err));
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [SAMPLE_W-1:0]  req_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [MAG_W-1:0]     rsp_uniform_value;
   logic signed [MAG_W-1:0]     rsp_companded_value;
   logic signed [UNI_ERR_W-1:0] rsp_uniform_error;
   logic signed [CMP_ERR_W-1:0] rsp_companded_error;

   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              hold_cycles_left = 0;
   int              cycle_count = 0;
   quantizer_ledger ledger = new();

   mu_law_and_uniform_quantizer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_uniform_value   (rsp_uniform_value),
      .rsp_companded_value (rsp_companded_value),
      .rsp_uniform_error   (rsp_uniform_error),
      .rsp_companded_error (rsp_companded_error)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mu_law_and_uniform_quantizer_core regression: fail");
         $finish;
      end
   end

   // Record input transfers and check output transfers
   always @(posedge clock) begin : monitor
      quant_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) ledger.note_sample(req_sample);
         if (rsp_valid && !rsp_stall) begin
            got.uni_val  = rsp_uniform_value;
            got.comp_val = rsp_companded_value;
            got.uni_err  = rsp_uniform_error;
            got.comp_err = rsp_companded_error;
            ledger.check_result(got);
         end
      end
   end

   // Result-side stall: random, or held high for a requested stretch
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_cycles_left > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles_left--;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < stall_pct);
         end
      end
   end

   // Offer one sample after random idle cycles; return at the transfer edge
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid  <= 1'b0;
         req_sample <= SAMPLE_W'($urandom);
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Mix of full-range noise, threshold neighbors, small and rounding-edge magnitudes
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int pick;
      int mag;
      pick = $urandom_range(99, 0);
      if (pick < 35) return SAMPLE_W'($urandom);
      if (pick < 65) begin
         mag = ledger.threshold_rom[$urandom_range(ledger.level_count, 1)]
               + $urandom_range(2, 0) - 1;
      end else if (pick < 85) begin
         mag = $urandom_range(2047, 0);
      end else begin
         mag = $urandom_range(255, 0) * UNIFORM_STEP + HALF_STEP - 1 + $urandom_range(1, 0);
      end
      if (mag > MAG_CEILING) mag = MAG_CEILING;
      if (mag == MAG_CEILING || $urandom_range(1, 0) == 1) return SAMPLE_W'(-mag);
      return SAMPLE_W'(mag);
   endfunction

   task automatic run_phase(input int count, input int idle_pct, input int stall_rate);
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      repeat (count) send_sample(pick_sample());
   endtask

   initial begin : stimulus
      logic signed [SAMPLE_W-1:0] directed[$];
      int                         top;
      top = ledger.level_count;
      // zero, unit, rounding edges, full-scale extremes, bit patterns
      directed = '{0, 1, -1, 63, 64, -64, -65, 127, -128, 191, 32767, -32767, -32768,
                   32704, -32704, 16'h5555, 16'hAAAA};
      // first, second, middle and last compressed-domain thresholds
      directed.push_back(SAMPLE_W'(ledger.threshold_rom[1] - 1));
      directed.push_back(SAMPLE_W'(ledger.threshold_rom[1]));
      directed.push_back(SAMPLE_W'(-ledger.threshold_rom[2]));
      directed.push_back(SAMPLE_W'(ledger.threshold_rom[top / 2]));
      directed.push_back(SAMPLE_W'(-(ledger.threshold_rom[top / 2] - 1)));
      directed.push_back(SAMPLE_W'(-ledger.threshold_rom[top]));
      directed.push_back(SAMPLE_W'(-(ledger.threshold_rom[top] - 1)));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_sample(directed[i]);
      run_phase(230, 0, 0);
      run_phase(230, 79, 0);
      run_phase(230, 0, 79);
      run_phase(230, 12, 12);

      // hold off the result side long enough for the pipe to back up
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_cycles_left = HOLD_OFF_LEN;
      repeat (80) send_sample(pick_sample());

      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_quants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0) begin
         $display("mu_law_and_uniform_quantizer_core regression: pass");
      end else begin
         $display("mu_law_and_uniform_quantizer_core regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/mluq_pkg.sv
rtl/mu_law_and_uniform_quantizer_core.sv
tb/sv/tb.sv
